// File: design/imsu_pkg.sv
// Shared constants, register indexes and controller/datapath types for the Ising spin update core.
package imsu_pkg;

    localparam int SIDE_X = 64;
    localparam int SIDE_Y = 64;
    localparam int X_W    = $clog2(SIDE_X);
    localparam int Y_W    = $clog2(SIDE_Y);

    localparam int SITE_W   = 6;
    localparam int DRAW_W   = 16;
    localparam int COUPLE_W = 16;
    localparam int THR_W    = 16;
    localparam int IDX_W    = 4;
    localparam int MAG_W    = 14;
    localparam int CNT_W    = 24;
    localparam int OP_W     = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_TOP  = 3'd4;

    localparam logic [COUPLE_W-1:0] COUPLING_RESET = 16'd4096;
    localparam logic [MAG_W-1:0]    MAG_RESET      = MAG_W'(SIDE_X * SIDE_Y);
    localparam logic [CNT_W-1:0]    CNT_MAX        = {CNT_W{1'b1}};

    typedef struct packed {
        logic           load;
        logic           capture;
        logic           finish;
        logic           clr_we;
        logic [Y_W-1:0] clr_row;
    } imsu_cmd_t;

    typedef struct packed {
        logic out_free;
    } imsu_status_t;

endpackage

// File: design/imsu_ctrl.sv
// Controller: clearing pass after reset, then accept / read / evaluate sequence per item.
module imsu_ctrl import imsu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  imsu_status_t status,
    output imsu_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [Y_W-1:0] row_cnt_reg, row_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            row_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.clr_row  = row_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we   = 1'b1;
                row_cnt_next = row_cnt_reg + 1'b1;
                if (row_cnt_reg == Y_W'(SIDE_Y - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.capture = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: design/imsu_datapath.sv
// Datapath: lattice row memory, configuration registers, flip decision, counters and output register.
module imsu_datapath import imsu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  imsu_cmd_t            cmd,
    output imsu_status_t         status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [SIDE_X-1:0] row_mem [SIDE_Y];

    logic [COUPLE_W-1:0] coupling_x_reg, coupling_y_reg;
    logic [CFG_W-1:0]    table_low_reg, table_mid_reg;
    logic [THR_W-1:0]    table_top_reg;

    logic [OP_W-1:0]   op_reg;
    logic [X_W-1:0]    x_reg;
    logic [Y_W-1:0]    y_reg;
    logic              wval_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic [SIDE_X-1:0] rd_a_reg, rd_b_reg, row_reg;
    logic              yp_bit_reg;

    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [OP_W-1:0]   in_op;
    logic [X_W-1:0]    in_x;
    logic [Y_W-1:0]    in_y;
    logic [Y_W-1:0]    in_yp, ym;
    logic [Y_W-1:0]    addr_a, addr_b;
    logic [X_W-1:0]    xp, xm;
    logic              s_cur, s_xp, s_xm, s_yp, s_ym;
    logic [1:0]        eq_x, eq_y;
    logic [IDX_W-1:0]  idx;
    logic signed [17:0] cx_ext, cy_ext, term_x, term_y, de_half;
    logic              de_le0;
    logic [THR_W-1:0]  thr;
    logic              accept, do_flip, spin_new;
    logic [SIDE_X-1:0] row_new;
    logic              wr_en;
    logic [Y_W-1:0]    wr_addr;
    logic [SIDE_X-1:0] wr_data;

    assign in_op = s_tdata[1:0];
    assign in_x  = s_tdata[2 +: X_W];
    assign in_y  = s_tdata[8 +: Y_W];

    assign in_yp  = (in_y == Y_W'(SIDE_Y - 1)) ? '0 : in_y + 1'b1;
    assign ym     = (y_reg == '0) ? Y_W'(SIDE_Y - 1) : y_reg - 1'b1;
    assign addr_a = cmd.load ? in_y : y_reg;
    assign addr_b = cmd.load ? in_yp : ym;

    always_ff @(posedge aclk) begin
        rd_a_reg <= row_mem[addr_a];
        rd_b_reg <= row_mem[addr_b];
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coupling_x_reg <= COUPLING_RESET;
            coupling_y_reg <= COUPLING_RESET;
            table_low_reg  <= '0;
            table_mid_reg  <= '0;
            table_top_reg  <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_COUPLING_X: coupling_x_reg <= cfg_wdata[COUPLE_W-1:0];
                REG_COUPLING_Y: coupling_y_reg <= cfg_wdata[COUPLE_W-1:0];
                REG_TABLE_LOW:  table_low_reg  <= cfg_wdata;
                REG_TABLE_MID:  table_mid_reg  <= cfg_wdata;
                REG_TABLE_TOP:  table_top_reg  <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            x_reg    <= in_x;
            y_reg    <= in_y;
            wval_reg <= s_tdata[14];
            draw_reg <= s_tdata[15 +: DRAW_W];
        end
        if (cmd.capture) begin
            row_reg    <= rd_a_reg;
            yp_bit_reg <= rd_b_reg[x_reg];
        end
    end

    // evaluate: row y held in row_reg, row y-1 in rd_b_reg
    assign xp    = (x_reg == X_W'(SIDE_X - 1)) ? '0 : x_reg + 1'b1;
    assign xm    = (x_reg == '0) ? X_W'(SIDE_X - 1) : x_reg - 1'b1;
    assign s_cur = row_reg[x_reg];
    assign s_xp  = row_reg[xp];
    assign s_xm  = row_reg[xm];
    assign s_yp  = yp_bit_reg;
    assign s_ym  = rd_b_reg[x_reg];

    assign eq_x = {1'b0, s_cur == s_xp} + {1'b0, s_cur == s_xm};
    assign eq_y = {1'b0, s_cur == s_yp} + {1'b0, s_cur == s_ym};
    assign idx  = {eq_x, 2'b00} - {2'b00, eq_x} + {2'b00, eq_y};

    assign cx_ext = 18'(signed'(coupling_x_reg));
    assign cy_ext = 18'(signed'(coupling_y_reg));

    always_comb begin
        case (eq_x)
            2'd0:    term_x = -cx_ext;
            2'd2:    term_x = cx_ext;
            default: term_x = '0;
        endcase
        case (eq_y)
            2'd0:    term_y = -cy_ext;
            2'd2:    term_y = cy_ext;
            default: term_y = '0;
        endcase
    end

    assign de_half = term_x + term_y;
    assign de_le0  = de_half[17] || (de_half == '0);

    always_comb begin
        case (idx)
            4'd0:    thr = table_low_reg[15:0];
            4'd1:    thr = table_low_reg[31:16];
            4'd2:    thr = table_low_reg[47:32];
            4'd3:    thr = table_low_reg[63:48];
            4'd4:    thr = table_mid_reg[15:0];
            4'd5:    thr = table_mid_reg[31:16];
            4'd6:    thr = table_mid_reg[47:32];
            4'd7:    thr = table_mid_reg[63:48];
            default: thr = table_top_reg;
        endcase
    end

    assign accept  = de_le0 || (draw_reg < thr);
    assign do_flip = (op_reg == OP_FLIP) && accept;

    always_comb begin
        spin_new = s_cur;
        mag_next = mag_reg;
        cnt_next = cnt_reg;
        case (op_reg)
            OP_WRITE: begin
                spin_new = wval_reg;
                if (wval_reg != s_cur) begin
                    mag_next = wval_reg ? mag_reg + MAG_W'(2) : mag_reg - MAG_W'(2);
                end
            end
            OP_FLIP: begin
                if (accept) begin
                    spin_new = ~s_cur;
                    mag_next = s_cur ? mag_reg - MAG_W'(2) : mag_reg + MAG_W'(2);
                    if (cnt_reg != CNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                cnt_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        row_new        = row_reg;
        row_new[x_reg] = spin_new;
    end

    assign wr_en   = cmd.clr_we || cmd.finish;
    assign wr_addr = cmd.clr_we ? cmd.clr_row : y_reg;
    assign wr_data = cmd.clr_we ? {SIDE_X{1'b1}} : row_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg      <= MAG_RESET;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                mag_reg      <= mag_next;
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {4'b0000, cnt_next, mag_next,
                            (op_reg == OP_FLIP) ? idx : IDX_W'(0), do_flip, spin_new};
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

// File: design/ising_metropolis_spin_update_core.sv
// Top level of the Metropolis single-spin-flip core for a periodic 64 x 64 Ising lattice.
//
// Input stream (s_): one item per operation: write spin, attempt flip, read spin or clear
// the flip counter, on the site given by its column and row.
// Result stream (m_): exactly one item per input item, in order: the site's spin after the
// operation, the flip flag, the neighbor configuration index, magnetization, flip count.
// Configuration: cfg_wen / cfg_index / cfg_wdata write couplings and acceptance thresholds;
// write only while the core holds no item in flight.
// Lattice rows sit in a row-wide memory with two read ports and one write port.
// An accepted item passes through the read and evaluate states before its result is registered.
// A new item is taken only after the last one is done (accept with rows y and y+1 read, read
// row y-1, evaluate and write back row y), an order set by the row memory read sequence.
// Reset: aresetn sets couplings to 1.0, thresholds and flip count to zero, magnetization to
// 4096, then a clearing pass sets all 64 rows to spin up, during which s_tready stays low.
// Stall: a result waits in the output register while m_tready is low; the next item is
// still accepted and computed, and holds in evaluation until the output register frees.
module ising_metropolis_spin_update_core import imsu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] operation, [7:2] site_x, [13:8] site_y, [14] spin_value, [30:15] random_draw
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] spin_after, [1] flipped, [5:2] config_index, [19:6] magnetization,
    // [43:20] flip_count
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    imsu_cmd_t    cmd;
    imsu_status_t status;

    imsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    imsu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: design/imsu_checker.sv
// Port-level checker for the Ising spin update core, bound to the top level.
module imsu_checker import imsu_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // clearing pass holds off input right after reset
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    a_flip_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[43:20] != '0)
        else $error("accepted flip with zero flip count");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:2] <= 4'd8)
        else $error("configuration index out of range");

endmodule

bind ising_metropolis_spin_update_core imsu_checker u_imsu_checker (.*);
